@@ hw/rtl/gwc_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gwc_pkg
// Shared constants and types of the gray window convolution unit.
// ---------------------------------------------------------------------------
package gwc_pkg;

   localparam int FILTER_SIZE = 7;
   localparam int TAPS        = FILTER_SIZE * FILTER_SIZE;
   localparam int LINES       = FILTER_SIZE - 1;
   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 4096;

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int WID_W   = 11;
   localparam int HGT_W   = 13;
   localparam int GRAY_W  = 16;
   localparam int COEF_W  = 16;
   localparam int IDX_W   = 6;
   localparam int PROD_W  = GRAY_W + COEF_W + 1;
   localparam int ROWS_W  = PROD_W + $clog2(FILTER_SIZE);
   localparam int ACC_W   = PROD_W + $clog2(TAPS);
   localparam int FRAC_W  = 20;

   localparam logic [WID_W-1:0] WIDTH_RESET  = WID_W'(512);
   localparam logic [HGT_W-1:0] HEIGHT_RESET = HGT_W'(512);

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_COEF  = 1'b1;

   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int OUT_DEPTH   = 4;
   localparam int OPTR_W      = $clog2(OUT_DEPTH);

   // red 0.3, green 0.59, blue 0.11 in Q0.8
   localparam logic [7:0] WEIGHT_RED   = 8'd77;
   localparam logic [7:0] WEIGHT_GREEN = 8'd151;
   localparam logic [7:0] WEIGHT_BLUE  = 8'd28;

   typedef struct packed {
      logic                     kind;
      logic [GRAY_W-1:0]        gray;
      logic [IDX_W-1:0]         coef_index;
      logic signed [COEF_W-1:0] coef_value;
      logic [COL_W-1:0]         column;
      logic                     emit;
      logic                     last;
   } item_type;

   typedef struct packed {
      logic [7:0] pixel_value;
      logic       clipped;
      logic       last_pixel;
   } result_type;

endpackage

@@ hw/rtl/gray_window_convolution_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gray_window_convolution_unit
// Streaming 7x7 gray correlation filter with line buffers.
// ---------------------------------------------------------------------------
// Takes one item per clock, a raster-order RGB pixel or a coefficient write,
// and keeps taking one per clock as long as results are popped. A pixel that
// completes an interior window yields its result through the item queue, the
// line-store read, the window update, the 49 tap multipliers and the adder
// tree (row sums, then the total). Border pixels and coefficient writes give
// no result. The line store holds six lines of 1024 gray values as one
// 96-bit-wide memory, read and rewritten once per pixel. Write image_width and
// image_height only while the block is idle.
// ---------------------------------------------------------------------------
module gray_window_convolution_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic                              req_kind,
   input  logic [7:0]                        req_red,
   input  logic [7:0]                        req_green,
   input  logic [7:0]                        req_blue,
   input  logic [gwc_pkg::IDX_W-1:0]         req_coef_index,
   input  logic signed [gwc_pkg::COEF_W-1:0] req_coef_value,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [7:0]                        rsp_pixel_value,
   output logic                              rsp_clipped,
   output logic                              rsp_last_pixel,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic                              csr_index,
   input  logic [gwc_pkg::HGT_W-1:0]         csr_data
);

   gwc_pkg::item_type   front_item, head_item;
   gwc_pkg::result_type head_res;
   logic                accept, q_valid, q_pop;

   assign csr_ready = 1'b1;
   assign accept    = req_push && !req_full;

   gwc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .kind       (req_kind),
      .red        (req_red),
      .green      (req_green),
      .blue       (req_blue),
      .coef_index (req_coef_index),
      .coef_value (req_coef_value),
      .cfg_write  (csr_valid && csr_ready),
      .cfg_index  (csr_index),
      .cfg_data   (csr_data),
      .item       (front_item)
   );

   gwc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_item (front_item),
      .full      (req_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .head      (head_item)
   );

   gwc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (q_valid),
      .item       (head_item),
      .item_pop   (q_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_head   (head_res)
   );

   assign rsp_pixel_value = head_res.pixel_value;
   assign rsp_clipped     = head_res.clipped;
   assign rsp_last_pixel  = head_res.last_pixel;

endmodule

@@ hw/rtl/gwc_front.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gwc_front
// Accepts items, converts pixels to gray, tracks the raster position and
// marks pixels that complete an interior window.
// ---------------------------------------------------------------------------
module gwc_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic                              kind,
   input  logic [7:0]                        red,
   input  logic [7:0]                        green,
   input  logic [7:0]                        blue,
   input  logic [gwc_pkg::IDX_W-1:0]         coef_index,
   input  logic signed [gwc_pkg::COEF_W-1:0] coef_value,
   input  logic                              cfg_write,
   input  logic                              cfg_index,
   input  logic [gwc_pkg::HGT_W-1:0]         cfg_data,
   output gwc_pkg::item_type                 item
);

   logic [gwc_pkg::WID_W-1:0] width_ff, width_in;
   logic [gwc_pkg::HGT_W-1:0] height_ff, height_in;
   logic [gwc_pkg::COL_W-1:0] col_ff, col_in;
   logic [gwc_pkg::ROW_W-1:0] row_ff, row_in;
   logic [gwc_pkg::WID_W-1:0] w_use;
   logic [gwc_pkg::HGT_W-1:0] h_use;
   logic [gwc_pkg::WID_W-1:0] col_next;
   logic [gwc_pkg::HGT_W-1:0] row_next;
   logic [gwc_pkg::WID_W-1:0] col_ext;
   logic [gwc_pkg::HGT_W-1:0] row_ext;

   always_comb begin
      if (width_ff < gwc_pkg::WID_W'(gwc_pkg::FILTER_SIZE))
         w_use = gwc_pkg::WID_W'(gwc_pkg::FILTER_SIZE);
      else if (width_ff > gwc_pkg::WID_W'(gwc_pkg::MAX_WIDTH))
         w_use = gwc_pkg::WID_W'(gwc_pkg::MAX_WIDTH);
      else
         w_use = width_ff;
      if (height_ff < gwc_pkg::HGT_W'(gwc_pkg::FILTER_SIZE))
         h_use = gwc_pkg::HGT_W'(gwc_pkg::FILTER_SIZE);
      else if (height_ff > gwc_pkg::HGT_W'(gwc_pkg::MAX_HEIGHT))
         h_use = gwc_pkg::HGT_W'(gwc_pkg::MAX_HEIGHT);
      else
         h_use = height_ff;
   end

   assign col_ext  = gwc_pkg::WID_W'(col_ff);
   assign row_ext  = gwc_pkg::HGT_W'(row_ff);
   assign col_next = col_ext + 1'b1;
   assign row_next = row_ext + 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (cfg_write) begin
         if (cfg_index == gwc_pkg::REG_WIDTH)
            width_in = cfg_data[gwc_pkg::WID_W-1:0];
         else
            height_in = cfg_data;
      end
      col_in = col_ff;
      row_in = row_ff;
      if (accept && kind == gwc_pkg::KIND_PIXEL) begin
         if (col_next >= w_use) begin
            col_in = '0;
            row_in = (row_next >= h_use) ? '0 : row_next[gwc_pkg::ROW_W-1:0];
         end else begin
            col_in = col_next[gwc_pkg::COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= gwc_pkg::WIDTH_RESET;
         height_ff <= gwc_pkg::HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

   always_comb begin
      item.kind       = kind;
      item.gray       = 16'(red) * 16'(gwc_pkg::WEIGHT_RED)
                      + 16'(green) * 16'(gwc_pkg::WEIGHT_GREEN)
                      + 16'(blue) * 16'(gwc_pkg::WEIGHT_BLUE);
      item.coef_index = coef_index;
      item.coef_value = coef_value;
      item.column     = col_ff;
      item.emit       = (col_ext >= gwc_pkg::WID_W'(gwc_pkg::LINES))
                     && (row_ext >= gwc_pkg::HGT_W'(gwc_pkg::LINES))
                     && (col_ext < w_use) && (row_ext < h_use);
      item.last       = (row_next == h_use) && (col_next == w_use);
   end

endmodule

@@ hw/rtl/gwc_queue.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gwc_queue
// Short item queue between the front and the back.
// ---------------------------------------------------------------------------
module gwc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  gwc_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output gwc_pkg::item_type head
);

   gwc_pkg::item_type          slot_ff [gwc_pkg::QUEUE_DEPTH];
   logic [gwc_pkg::QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [gwc_pkg::QPTR_W:0]   cnt_ff, cnt_in;

   assign full  = (cnt_ff == (gwc_pkg::QPTR_W+1)'(gwc_pkg::QUEUE_DEPTH));
   assign valid = (cnt_ff != '0);
   assign head  = slot_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (gwc_pkg::QPTR_W+1)'(push) - (gwc_pkg::QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_item;
   end

endmodule

@@ hw/rtl/gwc_back.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gwc_back
// Line store, window, coefficient registers, multiply-accumulate pipeline
// and result queue.
// ---------------------------------------------------------------------------
module gwc_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  gwc_pkg::item_type  item,
   output logic               item_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output gwc_pkg::result_type rsp_head
);

   localparam int FS = gwc_pkg::FILTER_SIZE;
   localparam int GW = gwc_pkg::GRAY_W;

   logic [gwc_pkg::LINES*GW-1:0] line_mem [gwc_pkg::MAX_WIDTH];
   logic [gwc_pkg::LINES*GW-1:0] rd_ff;

   logic                    en;
   logic                    s1_v_ff;
   gwc_pkg::item_type       s1_ff;
   logic                    s2_v_ff, s2_last_ff;
   logic                    s3_v_ff, s3_last_ff;
   logic                    s4_v_ff, s4_last_ff;
   logic                    s5_v_ff, s5_last_ff;

   logic [GW-1:0]                       win_ff  [gwc_pkg::TAPS];
   logic signed [gwc_pkg::COEF_W-1:0]   coef_ff [gwc_pkg::TAPS];
   logic signed [gwc_pkg::PROD_W-1:0]   prod_ff [gwc_pkg::TAPS];
   logic signed [gwc_pkg::ROWS_W-1:0]   rsum_ff [FS];
   logic signed [gwc_pkg::ROWS_W-1:0]   rsum_in [FS];
   logic signed [gwc_pkg::ACC_W-1:0]    acc_ff, acc_in;
   logic [GW-1:0]                       colv [FS];
   logic                                s1_pixel;

   gwc_pkg::result_type        out_ff [gwc_pkg::OUT_DEPTH];
   gwc_pkg::result_type        res;
   logic [gwc_pkg::OPTR_W-1:0] owr_ff, ord_ff;
   logic [gwc_pkg::OPTR_W:0]   ocnt_ff;
   logic                       ofull, opush, opop;

   assign ofull    = (ocnt_ff == (gwc_pkg::OPTR_W+1)'(gwc_pkg::OUT_DEPTH));
   assign en       = !(s5_v_ff && ofull);
   assign item_pop = en && item_valid;
   assign s1_pixel = s1_v_ff && (s1_ff.kind == gwc_pkg::KIND_PIXEL);

   always_comb begin
      for (int k = 0; k < gwc_pkg::LINES; k++) colv[k] = rd_ff[k*GW +: GW];
      colv[gwc_pkg::LINES] = s1_ff.gray;
   end

   // stage 1: fetch the stored column
   always_ff @(posedge clock) begin
      if (en) begin
         rd_ff <= line_mem[item.column];
         s1_ff <= item;
      end
   end

   // stage 2: write back the shifted column, slide the window or load a coefficient
   always_ff @(posedge clock) begin
      if (en && s1_pixel)
         line_mem[s1_ff.column] <= {s1_ff.gray, rd_ff[gwc_pkg::LINES*GW-1:GW]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < gwc_pkg::TAPS; t++) begin
            win_ff[t]  <= '0;
            coef_ff[t] <= '0;
         end
      end else if (en && s1_v_ff) begin
         if (s1_ff.kind == gwc_pkg::KIND_PIXEL) begin
            for (int k = 0; k < FS; k++) begin
               for (int dc = 0; dc < FS - 1; dc++)
                  win_ff[k*FS+dc] <= win_ff[k*FS+dc+1];
               win_ff[k*FS+FS-1] <= colv[k];
            end
         end else if (s1_ff.coef_index < gwc_pkg::IDX_W'(gwc_pkg::TAPS)) begin
            coef_ff[s1_ff.coef_index] <= s1_ff.coef_value;
         end
      end
   end

   // stage 3: one multiplier per tap
   always_ff @(posedge clock) begin
      if (en) begin
         for (int t = 0; t < gwc_pkg::TAPS; t++)
            prod_ff[t] <= coef_ff[t] * $signed({1'b0, win_ff[t]});
      end
   end

   always_comb begin
      for (int k = 0; k < FS; k++) begin
         rsum_in[k] = '0;
         for (int dc = 0; dc < FS; dc++)
            rsum_in[k] = rsum_in[k] + gwc_pkg::ROWS_W'(prod_ff[k*FS+dc]);
      end
      acc_in = '0;
      for (int k = 0; k < FS; k++)
         acc_in = acc_in + gwc_pkg::ACC_W'(rsum_ff[k]);
   end

   // stages 4 and 5: row sums, then the total
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < FS; k++) rsum_ff[k] <= rsum_in[k];
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= item_valid;
         s2_v_ff <= s1_pixel && s1_ff.emit;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
         s5_v_ff <= s4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_last_ff <= s1_ff.last;
         s3_last_ff <= s2_last_ff;
         s4_last_ff <= s3_last_ff;
         s5_last_ff <= s4_last_ff;
      end
   end

   // truncate the Q.20 sum and saturate
   always_comb begin
      res.last_pixel = s5_last_ff;
      if (acc_ff < 0) begin
         res.pixel_value = 8'd0;
         res.clipped     = 1'b1;
      end else if (acc_ff[gwc_pkg::ACC_W-1:gwc_pkg::FRAC_W+8] != '0) begin
         res.pixel_value = 8'd255;
         res.clipped     = 1'b1;
      end else begin
         res.pixel_value = acc_ff[gwc_pkg::FRAC_W +: 8];
         res.clipped     = 1'b0;
      end
   end

   assign opush     = s5_v_ff && !ofull;
   assign opop      = rsp_pop && !rsp_empty;
   assign rsp_empty = (ocnt_ff == '0);
   assign rsp_head  = out_ff[ord_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         owr_ff  <= '0;
         ord_ff  <= '0;
         ocnt_ff <= '0;
      end else begin
         if (opush) owr_ff <= owr_ff + 1'b1;
         if (opop)  ord_ff <= ord_ff + 1'b1;
         ocnt_ff <= ocnt_ff + (gwc_pkg::OPTR_W+1)'(opush) - (gwc_pkg::OPTR_W+1)'(opop);
      end
   end

   always_ff @(posedge clock) begin
      if (opush) out_ff[owr_ff] <= res;
   end

endmodule
